// ----- src/binary_blob_corner_scanner_defines.svh -----
// ---------------------------------------------------------------------------
// Binary blob corner scanner assertion macros
// Shared helpers for the concurrent checks in the scanner modules. They
// expect signals named clk and rst in the scope where they are used.
// ---------------------------------------------------------------------------
`ifndef BINARY_BLOB_CORNER_SCANNER_DEFINES_SVH
`define BINARY_BLOB_CORNER_SCANNER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BBCS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bbcs check failed");

// Next-cycle implication, checked outside reset.
`define BBCS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bbcs check failed");

`endif

// ----- src/bbcs_pkg.sv -----
// ---------------------------------------------------------------------------
// Binary blob corner scanner package
// Pixel classes, field widths, register indexes and the shared stage record.
// ---------------------------------------------------------------------------
package bbcs_pkg;

  localparam int PIX_W = 8;
  localparam int POS_W = 11;
  localparam int CFG_W = 12;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  localparam logic [PIX_W-1:0] PIX_BRIGHT = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_DARK   = 8'h00;

  localparam logic [1:0] CLS_DARK   = 2'd0;
  localparam logic [1:0] CLS_BRIGHT = 2'd1;
  localparam logic [1:0] CLS_OTHER  = 2'd2;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
  localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;

  // Record handed from the line buffer stage to the detector.
  typedef struct packed {
    logic [1:0] cls;
    logic [1:0] stored;
    logic       first_row;
    logic       first_col;
    logic       last_pix;
  } pix_info_t;

  function automatic logic [1:0] classify(input logic [PIX_W-1:0] p);
    logic [1:0] c;
    if (p == PIX_BRIGHT) c = CLS_BRIGHT;
    else if (p == PIX_DARK) c = CLS_DARK;
    else c = CLS_OTHER;
    return c;
  endfunction

endpackage

// ----- src/bbcs_pix_if.sv -----
// ---------------------------------------------------------------------------
// Pixel channel
// Valid/ready channel carrying one binarized pixel per beat.
// ---------------------------------------------------------------------------
interface bbcs_pix_if import bbcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;

  modport source(output valid, output pixel, input ready);
  modport sink(input valid, input pixel, output ready);
endinterface

// ----- src/bbcs_res_if.sv -----
// ---------------------------------------------------------------------------
// Result channel
// Valid/ready channel carrying one corner report per beat.
// ---------------------------------------------------------------------------
interface bbcs_res_if import bbcs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] left_x;
  logic [POS_W-1:0] top_y;
  logic [POS_W-1:0] right_x;
  logic [POS_W-1:0] bottom_y;
  logic             first_found;
  logic             last_found;

  modport source(output valid, output left_x, output top_y, output right_x,
                 output bottom_y, output first_found, output last_found,
                 input ready);
  modport sink(input valid, input left_x, input top_y, input right_x,
               input bottom_y, input first_found, input last_found,
               output ready);
endinterface

// ----- src/bbcs_regs.sv -----
// ---------------------------------------------------------------------------
// Configuration registers
// APB-style frame width and height registers.
// ---------------------------------------------------------------------------
module bbcs_regs import bbcs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready,
  output logic [CFG_W-1:0]  frame_width,
  output logic [CFG_W-1:0]  frame_height
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_RESET;
      frame_height <= HEIGHT_RESET;
    end else if (wr_en) begin
      if (paddr[2] == CFG_IDX_HEIGHT) begin
        frame_height <= pwdata[CFG_W-1:0];
      end else begin
        frame_width <= pwdata[CFG_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == CFG_IDX_HEIGHT) begin
      prdata = APB_DW'(frame_height);
    end else begin
      prdata = APB_DW'(frame_width);
    end
  end

endmodule

// ----- src/bbcs_front.sv -----
// ---------------------------------------------------------------------------
// Raster counter and line buffer
// Counts column and row, classifies the pixel and reads the class of the
// pixel above from a one-row memory, registering everything for the detector.
// ---------------------------------------------------------------------------
`include "binary_blob_corner_scanner_defines.svh"

module bbcs_front import bbcs_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  localparam int XW = $clog2(MAX_WIDTH),
  localparam int YW = $clog2(MAX_HEIGHT)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [CFG_W-1:0] frame_width,
  input  logic [CFG_W-1:0] frame_height,
  bbcs_pix_if.sink         pix,
  output logic             s1_valid,
  input  logic             s1_take,
  output pix_info_t        s1_info,
  output logic [XW-1:0]    s1_col,
  output logic [YW-1:0]    s1_row
);

  logic [1:0]    line_mem [MAX_WIDTH];
  logic [1:0]    stored;
  logic [XW-1:0] col;
  logic [YW-1:0] row;
  logic [XW-1:0] x_lim;
  logic [YW-1:0] y_lim;
  logic [1:0]    cls;
  logic          last_col;
  logic          last_pix;
  logic          accept;
  logic [1:0]    s1_cls;
  logic          s1_last;

  // Last column and last row index; zero acts as one, oversize is clamped.
  always_comb begin
    if (frame_width == '0) begin
      x_lim = '0;
    end else if (32'(frame_width) > 32'(MAX_WIDTH)) begin
      x_lim = XW'(MAX_WIDTH - 1);
    end else begin
      x_lim = XW'(frame_width - 12'd1);
    end
    if (frame_height == '0) begin
      y_lim = '0;
    end else if (32'(frame_height) > 32'(MAX_HEIGHT)) begin
      y_lim = YW'(MAX_HEIGHT - 1);
    end else begin
      y_lim = YW'(frame_height - 12'd1);
    end
  end

  assign cls      = classify(pix.pixel);
  assign last_col = (col >= x_lim);
  assign last_pix = last_col && (row >= y_lim);
  assign pix.ready = !s1_valid || s1_take;
  assign accept   = pix.valid && pix.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col      <= '0;
      row      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        if (last_pix) begin
          col <= '0;
          row <= '0;
        end else if (last_col) begin
          col <= '0;
          row <= row + YW'(1);
        end else begin
          col <= col + XW'(1);
        end
      end else if (s1_take) begin
        s1_valid <= 1'b0;
      end
    end
  end

  // Payload of the stage register.
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cls  <= cls;
      s1_col  <= col;
      s1_row  <= row;
      s1_last <= last_pix;
    end
  end

  // Read-first line memory: the old entry is the pixel one row above.
  always_ff @(posedge clk) begin
    if (accept) begin
      stored        <= line_mem[col];
      line_mem[col] <= cls;
    end
  end

  always_comb begin
    s1_info.cls       = s1_cls;
    s1_info.stored    = stored;
    s1_info.first_row = (s1_row == '0);
    s1_info.first_col = (s1_col == '0);
    s1_info.last_pix  = s1_last;
  end

  `BBCS_ASSERT_NEXT(a_wrap_frame, accept && last_pix, col == '0 && row == '0)
  `BBCS_ASSERT_NEXT(a_stage_hold, s1_valid && !s1_take, s1_valid && $stable(s1_col))
  `BBCS_ASSERT_NOW(a_ready_free, !s1_valid, pix.ready)

endmodule

// ----- src/bbcs_detect.sv -----
// ---------------------------------------------------------------------------
// Corner detector
// Tests the 2x2 neighborhood of each pixel, tracks the opening corner and
// issues the single report of a frame into the result register.
// ---------------------------------------------------------------------------
`include "binary_blob_corner_scanner_defines.svh"

module bbcs_detect import bbcs_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048,
  localparam int XW = $clog2(MAX_WIDTH),
  localparam int YW = $clog2(MAX_HEIGHT)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s1_valid,
  output logic          s1_take,
  input  pix_info_t     s1_info,
  input  logic [XW-1:0] s1_col,
  input  logic [YW-1:0] s1_row,
  bbcs_res_if.source    res
);

  logic          opening_seen;
  logic          frame_reported;
  logic [XW-1:0] opening_col;
  logic [YW-1:0] opening_row;
  logic [1:0]    left_class;
  logic [1:0]    upper_left_class;
  logic [1:0]    up;
  logic [1:0]    left;
  logic [1:0]    ul;
  logic          open_hit;
  logic          close_hit;
  logic          emit;
  logic          emit_close;

  assign s1_take = s1_valid && (!res.valid || res.ready);

  // Neighbors outside the frame count as dark.
  assign up   = s1_info.first_row ? CLS_DARK : s1_info.stored;
  assign left = s1_info.first_col ? CLS_DARK : left_class;
  assign ul   = (s1_info.first_row || s1_info.first_col) ? CLS_DARK : upper_left_class;

  assign open_hit = !frame_reported && !opening_seen && s1_info.cls == CLS_BRIGHT &&
                    up == CLS_DARK && left == CLS_DARK && ul == CLS_DARK;
  assign close_hit = !frame_reported && opening_seen && s1_info.cls == CLS_DARK &&
                     up == CLS_BRIGHT && left == CLS_BRIGHT && ul == CLS_BRIGHT;
  assign emit_close = close_hit;
  assign emit = close_hit || (!frame_reported && s1_info.last_pix);

  always_ff @(posedge clk) begin
    if (rst) begin
      opening_seen     <= 1'b0;
      frame_reported   <= 1'b0;
      opening_col      <= '0;
      opening_row      <= '0;
      left_class       <= CLS_DARK;
      upper_left_class <= CLS_DARK;
    end else if (s1_take) begin
      if (s1_info.last_pix) begin
        opening_seen     <= 1'b0;
        frame_reported   <= 1'b0;
        opening_col      <= '0;
        opening_row      <= '0;
        left_class       <= CLS_DARK;
        upper_left_class <= CLS_DARK;
      end else begin
        left_class       <= s1_info.cls;
        upper_left_class <= up;
        if (open_hit) begin
          opening_seen <= 1'b1;
          opening_col  <= s1_col;
          opening_row  <= s1_row;
        end
        if (emit) begin
          frame_reported <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (s1_take && emit) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  // A corner found on the frame's last pixel is reported at once.
  always_ff @(posedge clk) begin
    if (s1_take && emit) begin
      if (open_hit) begin
        res.left_x      <= POS_W'(s1_col);
        res.top_y       <= POS_W'(s1_row);
        res.first_found <= 1'b1;
      end else begin
        res.left_x      <= opening_seen ? POS_W'(opening_col) : '0;
        res.top_y       <= opening_seen ? POS_W'(opening_row) : '0;
        res.first_found <= opening_seen;
      end
      res.right_x    <= emit_close ? POS_W'(s1_col) : '0;
      res.bottom_y   <= emit_close ? POS_W'(s1_row) : '0;
      res.last_found <= emit_close;
    end
  end

  `BBCS_ASSERT_NEXT(a_one_report, s1_take && emit && !s1_info.last_pix, frame_reported)
  `BBCS_ASSERT_NEXT(a_frame_clear, s1_take && s1_info.last_pix, !frame_reported && !opening_seen)
  `BBCS_ASSERT_NOW(a_no_open_zero, res.valid && !res.first_found, res.left_x == '0 && res.top_y == '0 && !res.last_found)

endmodule

// ----- src/binary_blob_corner_scanner.sv -----
// ---------------------------------------------------------------------------
// Binary blob corner scanner
// Finds the opening and closing corners of a bright blob in a binarized
// raster frame and reports them once per frame.
// ---------------------------------------------------------------------------
//   channel  dir  beat
//   pix      in   one pixel, raster order
//   res      out  one corner report per frame
//   apb      in   frame_width (0x0), frame_height (0x4)
//
// One pixel is taken per cycle unless stalled; a report passes the pixel stage, then the result register.
// The pixel above comes from a one-row line memory read at the column counter.
// A stalled result register holds the pixel stage, which then stops input.
// Reset clears counters and corner state; the line memory needs no clearing.
// ---------------------------------------------------------------------------
module binary_blob_corner_scanner import bbcs_pkg::*; #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic              clk,
  input  logic              rst,
  bbcs_pix_if.sink          pix,
  bbcs_res_if.source        res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);

  logic [CFG_W-1:0] frame_width;
  logic [CFG_W-1:0] frame_height;
  logic             s1_valid;
  logic             s1_take;
  pix_info_t        s1_info;
  logic [XW-1:0]    s1_col;
  logic [YW-1:0]    s1_row;

  bbcs_regs u_regs (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .frame_width  (frame_width),
    .frame_height (frame_height)
  );

  bbcs_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .pix          (pix),
    .s1_valid     (s1_valid),
    .s1_take      (s1_take),
    .s1_info      (s1_info),
    .s1_col       (s1_col),
    .s1_row       (s1_row)
  );

  bbcs_detect #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_detect (
    .clk      (clk),
    .rst      (rst),
    .s1_valid (s1_valid),
    .s1_take  (s1_take),
    .s1_info  (s1_info),
    .s1_col   (s1_col),
    .s1_row   (s1_row),
    .res      (res)
  );

endmodule

// ----- sim/binary_blob_corner_scanner_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Binary blob corner scanner testbench
// Streams mostly binarized frames through the scanner under random back-pressure.
// A cycle-free predictor rebuilds each frame's corner report and checks every
// report beat in order. Frame size changes happen only between frames, except
// for a few shrinks in the middle of a frame.
// ---------------------------------------------------------------------------
module binary_blob_corner_scanner_tb import bbcs_pkg::*; ();

  localparam int MAX_W = 2048;
  localparam int MAX_H = 2048;
  localparam int COL_W = $clog2(MAX_W);
  localparam int LATENCY_CYCLES = 4;
  localparam int IDLE_PCT = 18;
  localparam int RANDOM_PIXELS = 700;

  localparam logic [PIX_W-1:0] DIRECTED_PX [24] = '{
    8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd255, 8'd255, 8'd0,
    8'd0,   8'd255, 8'd0,   8'd7,
    8'd255, 8'd255, 8'd255, 8'd0,
    8'd1,   8'd2,   8'd254, 8'd128,
    8'd0,   8'd0,   8'd0,   8'd255
  };

  typedef enum int {STYLE_BLOB, STYLE_COIN, STYLE_NOISE} pixel_style_e;

  typedef struct packed {
    logic [POS_W-1:0] left_x;
    logic [POS_W-1:0] top_y;
    logic [POS_W-1:0] right_x;
    logic [POS_W-1:0] bottom_y;
    logic             first_found;
    logic             last_found;
  } corner_report_t;

  function automatic int effective_size(input int v, input int limit);
    if (v == 0) return 1;
    if (v > limit) return limit;
    return v;
  endfunction

  class corner_scoreboard;
    logic [CFG_W-1:0] frame_w;
    logic [CFG_W-1:0] frame_h;
    int col;
    int row;
    bit opening_hit;
    bit frame_done;
    int open_col;
    int open_row;
    logic [1:0] left_cls;
    logic [1:0] upleft_cls;
    logic [1:0] row_above [MAX_W];
    corner_report_t expected_reports[$];
    int errors;

    function new();
      frame_w = WIDTH_RESET;
      frame_h = HEIGHT_RESET;
      col = 0;
      row = 0;
      opening_hit = 0;
      frame_done = 0;
      open_col = 0;
      open_row = 0;
      left_cls = CLS_DARK;
      upleft_cls = CLS_DARK;
      errors = 0;
      foreach (row_above[i]) row_above[i] = CLS_DARK;
    endfunction

    function void set_register(input logic idx, input logic [CFG_W-1:0] value);
      if (idx == CFG_IDX_WIDTH) frame_w = value;
      else frame_h = value;
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function logic [1:0] pixel_class(input logic [PIX_W-1:0] px);
      case (px)
        PIX_BRIGHT: return CLS_BRIGHT;
        PIX_DARK: return CLS_DARK;
        default: return CLS_OTHER;
      endcase
    endfunction

    function corner_report_t make_report(input int rx, input int by, input bit closed);
      corner_report_t rep;
      rep.left_x = opening_hit ? open_col[POS_W-1:0] : '0;
      rep.top_y = opening_hit ? open_row[POS_W-1:0] : '0;
      rep.right_x = rx[POS_W-1:0];
      rep.bottom_y = by[POS_W-1:0];
      rep.first_found = opening_hit;
      rep.last_found = closed;
      return rep;
    endfunction

    // Advance the frame position by one pixel beat and queue any report it causes.
    function void note_pixel(input logic [PIX_W-1:0] px);
      int w;
      int h;
      logic [1:0] cur;
      logic [1:0] up;
      logic [1:0] left;
      logic [1:0] ul;
      bit last_col;
      bit last_pix;
      bit emitted;
      w = effective_size(int'(frame_w), MAX_W);
      h = effective_size(int'(frame_h), MAX_H);
      cur = pixel_class(px);
      up = (row == 0) ? CLS_DARK : ((col < MAX_W) ? row_above[col[COL_W-1:0]] : CLS_DARK);
      left = (col == 0) ? CLS_DARK : left_cls;
      ul = (row == 0 || col == 0) ? CLS_DARK : upleft_cls;
      last_col = (col + 1 >= w);
      last_pix = last_col && (row + 1 >= h);
      emitted = 0;
      if (!frame_done) begin
        if (!opening_hit) begin
          if (cur == CLS_BRIGHT && up == CLS_DARK && left == CLS_DARK && ul == CLS_DARK) begin
            opening_hit = 1;
            open_col = col;
            open_row = row;
          end
        end else if (cur == CLS_DARK && up == CLS_BRIGHT && left == CLS_BRIGHT &&
                     ul == CLS_BRIGHT) begin
          expected_reports.push_back(make_report(col, row, 1'b1));
          frame_done = 1;
          emitted = 1;
        end
        if (!emitted && last_pix) begin
          expected_reports.push_back(make_report(0, 0, 1'b0));
          frame_done = 1;
        end
      end
      if (col < MAX_W) row_above[col[COL_W-1:0]] = cur;
      left_cls = cur;
      upleft_cls = up;
      if (last_pix) begin
        col = 0;
        row = 0;
        opening_hit = 0;
        frame_done = 0;
        open_col = 0;
        open_row = 0;
        left_cls = CLS_DARK;
        upleft_cls = CLS_DARK;
      end else if (last_col) begin
        col = 0;
        row = row + 1;
      end else begin
        col = col + 1;
      end
    endfunction

    function void compare_field(input string name, input int want, input int got);
      if (want != got) begin
        errors++;
        $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_report(input corner_report_t got);
      corner_report_t want;
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: report with none expected, expected none actual %p", $time, got);
        return;
      end
      want = expected_reports.pop_front();
      compare_field("left_x", int'(want.left_x), int'(got.left_x));
      compare_field("top_y", int'(want.top_y), int'(got.top_y));
      compare_field("right_x", int'(want.right_x), int'(got.right_x));
      compare_field("bottom_y", int'(want.bottom_y), int'(got.bottom_y));
      compare_field("first_found", int'(want.first_found), int'(got.first_found));
      compare_field("last_found", int'(want.last_found), int'(got.last_found));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  bbcs_pix_if pix_ch();
  bbcs_res_if res_ch();

  corner_scoreboard sb = new();
  bit steady;
  int cur_w;
  int cur_h;

  binary_blob_corner_scanner dut (
    .clk     (clk),
    .rst     (rst),
    .pix     (pix_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    res_ch.ready <= steady || ($urandom_range(99) >= 21);
  end

  // Pixel beats are noted before reports are checked, so a report can never
  // outrun the pixel that caused it.
  always @(posedge clk) begin
    corner_report_t got;
    if (!rst && pix_ch.valid && pix_ch.ready) sb.note_pixel(pix_ch.pixel);
    if (!rst && res_ch.valid && res_ch.ready) begin
      got.left_x = res_ch.left_x;
      got.top_y = res_ch.top_y;
      got.right_x = res_ch.right_x;
      got.bottom_y = res_ch.bottom_y;
      got.first_found = res_ch.first_found;
      got.last_found = res_ch.last_found;
      sb.check_report(got);
    end
  end

  task automatic write_reg(input logic idx, input int value);
    logic [APB_DW-1:0] data;
    data = $urandom;
    data[CFG_W-1:0] = value[CFG_W-1:0];
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.set_register(idx, value[CFG_W-1:0]);
    if (idx == CFG_IDX_WIDTH) cur_w = int'(value[CFG_W-1:0]);
    else cur_h = int'(value[CFG_W-1:0]);
    @(posedge clk);
  endtask

  task automatic send_pixel(input logic [PIX_W-1:0] p);
    int n;
    pix_ch.valid <= 1'b1;
    pix_ch.pixel <= p;
    do @(posedge clk); while (!pix_ch.ready);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      n = $urandom_range(1, 2);
      pix_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Hold the pixel channel until every queued report has been taken and the
  // pipeline has drained.
  task automatic wait_idle();
    pix_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (LATENCY_CYCLES) @(posedge clk);
  endtask

  task automatic set_size(input int w, input int h);
    wait_idle();
    write_reg(CFG_IDX_WIDTH, w);
    write_reg(CFG_IDX_HEIGHT, h);
  endtask

  task automatic send_frame(input pixel_style_e style);
    int w;
    int h;
    int x0;
    int x1;
    int y0;
    int y1;
    int hx;
    int hy;
    bit in_rect;
    logic [PIX_W-1:0] p;
    w = effective_size(cur_w, MAX_W);
    h = effective_size(cur_h, MAX_H);
    x0 = $urandom_range(w - 1);
    x1 = $urandom_range(w - 1, x0);
    y0 = $urandom_range(h - 1);
    y1 = $urandom_range(h - 1, y0);
    hx = $urandom_range(x1, x0);
    hy = $urandom_range(y1, y0);
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        case (style)
          STYLE_BLOB: begin
            // A bright rectangle with one dark hole can give both corner kinds.
            in_rect = (c >= x0 && c <= x1 && r >= y0 && r <= y1);
            p = (in_rect && !(c == hx && r == hy)) ? PIX_BRIGHT : PIX_DARK;
            if ($urandom_range(99) < 4) p = PIX_W'($urandom);
          end
          STYLE_COIN: begin
            p = $urandom_range(1) ? PIX_BRIGHT : PIX_DARK;
            if ($urandom_range(99) < 5) p = PIX_W'($urandom);
          end
          default: begin
            case ($urandom_range(2))
              0: p = PIX_DARK;
              1: p = PIX_BRIGHT;
              default: p = PIX_W'($urandom);
            endcase
          end
        endcase
        send_pixel(p);
      end
    end
  endtask

  initial begin
    int random_pixels;
    int w;
    int h;
    int pick;
    pixel_style_e style;
    rst <= 1'b1;
    pix_ch.valid <= 1'b0;
    pix_ch.pixel <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    steady = 0;
    cur_w = int'(WIDTH_RESET);
    cur_h = int'(HEIGHT_RESET);
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Blob with both corners, corner on the frame border, no match at all,
    // and an opening corner on the frame's last pixel.
    write_reg(CFG_IDX_WIDTH, 4);
    write_reg(CFG_IDX_HEIGHT, 3);
    for (int i = 0; i < 12; i++) send_pixel(DIRECTED_PX[i[4:0]]);
    set_size(2, 2);
    for (int i = 12; i < 24; i++) send_pixel(DIRECTED_PX[i[4:0]]);

    // Shrink in the middle of a 6x4 frame at column 3 of row 2: the next
    // beat closes both the row and the frame.
    set_size(6, 4);
    for (int i = 0; i < 15; i++) send_pixel($urandom_range(1) ? PIX_BRIGHT : PIX_DARK);
    set_size(2, 2);
    send_pixel(PIX_DARK);

    random_pixels = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      if ($urandom_range(2) == 0) begin
        pick = $urandom_range(19);
        w = (pick == 0) ? 0 : ((pick < 3) ? $urandom_range(9, 16) : $urandom_range(1, 8));
        pick = $urandom_range(19);
        h = (pick == 0) ? 0 : $urandom_range(1, 6);
        set_size(w, h);
      end
      pick = $urandom_range(99);
      style = (pick < 45) ? STYLE_BLOB : ((pick < 85) ? STYLE_COIN : STYLE_NOISE);
      steady = (random_pixels >= 300 && random_pixels < 420);
      send_frame(style);
      random_pixels += effective_size(cur_w, MAX_W) * effective_size(cur_h, MAX_H);
    end
    steady = 0;

    // Size extremes, kept to one or two rows or columns.
    set_size(0, 0);
    send_frame(STYLE_COIN);
    set_size(1, 1);
    send_frame(STYLE_COIN);
    // Oversize sizes are cut short a few beats in by a shrink that ends the frame.
    set_size(4095, 1);
    for (int i = 0; i < 6; i++) send_pixel($urandom_range(1) ? PIX_BRIGHT : PIX_DARK);
    set_size(2, 1);
    send_pixel(PIX_DARK);
    set_size(1, 4095);
    for (int i = 0; i < 6; i++) send_pixel($urandom_range(1) ? PIX_BRIGHT : PIX_DARK);
    set_size(1, 1);
    send_pixel(PIX_BRIGHT);
    set_size(0, 3);
    send_frame(STYLE_COIN);
    set_size(5, 0);
    send_frame(STYLE_BLOB);

    wait_idle();
    repeat (LATENCY_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
